// ===== rtl/core/atit_pkg.sv =====
// Shared widths, register indexes, reset values and types of the tick interval throttle.
`default_nettype none

package atit_pkg;

   localparam int unsigned ATIT_TIME_BITS_DEFAULT = 48;

   localparam int unsigned INTERVAL_BITS = 16;
   localparam int unsigned LIMIT_BITS    = 8;
   localparam int unsigned LATE_CNT_BITS = 9;
   localparam int unsigned ONTIME_BITS   = 8;
   localparam int unsigned CSR_IDX_BITS  = 3;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] REG_BASE_INTERVAL  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_MIN_INTERVAL   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_MAX_INTERVAL   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_INTERVAL_STEP  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_LATE_THRESHOLD = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_LATE_LIMIT     = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] REG_ONTIME_LIMIT   = 3'd6;

   // reset values
   localparam logic [INTERVAL_BITS-1:0] RST_BASE_INTERVAL  = 16'd100;
   localparam logic [INTERVAL_BITS-1:0] RST_MIN_INTERVAL   = 16'd10;
   localparam logic [INTERVAL_BITS-1:0] RST_MAX_INTERVAL   = 16'd1000;
   localparam logic [INTERVAL_BITS-1:0] RST_INTERVAL_STEP  = 16'd50;
   localparam logic [INTERVAL_BITS-1:0] RST_LATE_THRESHOLD = 16'd50;
   localparam logic [LIMIT_BITS-1:0]    RST_LATE_LIMIT     = 8'd3;
   localparam logic [LIMIT_BITS-1:0]    RST_ONTIME_LIMIT   = 8'd10;
   // effective base after reset: max(100, 10, 1)
   localparam logic [INTERVAL_BITS-1:0] RST_CUR_INTERVAL   = 16'd100;

   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_RESET = 1'b1;

   typedef struct packed {
      logic [INTERVAL_BITS-1:0] eff_base;
      logic [INTERVAL_BITS-1:0] max_interval;
      logic [INTERVAL_BITS-1:0] step;
      logic [INTERVAL_BITS-1:0] late_threshold;
      logic [LIMIT_BITS-1:0]    late_limit;
      logic [LIMIT_BITS-1:0]    ontime_limit;
   } atit_cfg_type;

   typedef struct packed {
      logic                     valid;
      logic [INTERVAL_BITS-1:0] value;
   } atit_reload_type;

   typedef struct packed {
      logic [INTERVAL_BITS-1:0] cur_interval;
      logic [LATE_CNT_BITS-1:0] late_cnt;
      logic [ONTIME_BITS-1:0]   ontime_cnt;
   } atit_state_type;

   // max(base, min, 1)
   function automatic logic [INTERVAL_BITS-1:0] eff_base_f(
      input logic [INTERVAL_BITS-1:0] base,
      input logic [INTERVAL_BITS-1:0] min_val
   );
      logic [INTERVAL_BITS-1:0] b;
      b = (base < min_val) ? min_val : base;
      if (b == '0) begin
         b = INTERVAL_BITS'(1);
      end
      return b;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/atit_csr.sv =====
// Configuration register file with effective base derivation and base reload request.
`default_nettype none

module atit_csr
   import atit_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_write_enable,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [INTERVAL_BITS-1:0] csr_write_data,
   output atit_cfg_type                  cfg,
   output atit_reload_type               reload
);

   logic [INTERVAL_BITS-1:0] base_ff, min_ff, max_ff, step_ff, thr_ff;
   logic [LIMIT_BITS-1:0]    late_lim_ff, ontime_lim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff       <= RST_BASE_INTERVAL;
         min_ff        <= RST_MIN_INTERVAL;
         max_ff        <= RST_MAX_INTERVAL;
         step_ff       <= RST_INTERVAL_STEP;
         thr_ff        <= RST_LATE_THRESHOLD;
         late_lim_ff   <= RST_LATE_LIMIT;
         ontime_lim_ff <= RST_ONTIME_LIMIT;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_BASE_INTERVAL:  base_ff       <= csr_write_data;
            REG_MIN_INTERVAL:   min_ff        <= csr_write_data;
            REG_MAX_INTERVAL:   max_ff        <= csr_write_data;
            REG_INTERVAL_STEP:  step_ff       <= csr_write_data;
            REG_LATE_THRESHOLD: thr_ff        <= csr_write_data;
            REG_LATE_LIMIT:     late_lim_ff   <= csr_write_data[LIMIT_BITS-1:0];
            REG_ONTIME_LIMIT:   ontime_lim_ff <= csr_write_data[LIMIT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.eff_base       = eff_base_f(base_ff, min_ff);
      cfg.max_interval   = max_ff;
      cfg.step           = step_ff;
      cfg.late_threshold = thr_ff;
      cfg.late_limit     = late_lim_ff;
      cfg.ontime_limit   = ontime_lim_ff;
      // base write reloads the interval from the value being written
      reload.valid = csr_write_enable && (csr_index == REG_BASE_INTERVAL);
      reload.value = eff_base_f(csr_write_data, min_ff);
   end

endmodule

`default_nettype wire

// ===== rtl/core/atit_step.sv =====
// Per-item next-state logic: lateness test, late/on-time run counters, grow and shrink.
`default_nettype none

module atit_step
   import atit_pkg::*;
#(
   parameter int unsigned TIME_BITS = ATIT_TIME_BITS_DEFAULT
) (
   input  wire atit_cfg_type             cfg,
   input  wire atit_state_type           state_cur,
   input  wire logic [TIME_BITS:0]       expected_cur,
   input  wire logic                     command,
   input  wire logic [TIME_BITS-1:0]     now_ms,
   output atit_state_type                state_nxt,
   output logic [TIME_BITS:0]            expected_nxt,
   output logic                          throttled,
   output logic                          interval_changed
);

   localparam int unsigned EXP_BITS = TIME_BITS + 1;
   localparam int unsigned CMP_BITS = TIME_BITS + 2;

   logic [CMP_BITS-1:0]        late_edge;
   logic                       is_late;
   logic [INTERVAL_BITS:0]     grown;
   logic [INTERVAL_BITS-2:0]   half;
   logic [INTERVAL_BITS:0]     shrink_floor;
   logic [LATE_CNT_BITS-1:0]   late_inc;
   logic [ONTIME_BITS-1:0]     ontime_inc;

   always_comb begin
      late_edge    = CMP_BITS'(expected_cur) + CMP_BITS'(cfg.late_threshold);
      is_late      = CMP_BITS'(now_ms) > late_edge;
      grown        = (INTERVAL_BITS+1)'(state_cur.cur_interval) + (INTERVAL_BITS+1)'(cfg.step);
      half         = cfg.step[INTERVAL_BITS-1:1];
      shrink_floor = (INTERVAL_BITS+1)'(cfg.eff_base) + (INTERVAL_BITS+1)'(half);
      late_inc     = state_cur.late_cnt + LATE_CNT_BITS'(1);
      ontime_inc   = state_cur.ontime_cnt + ONTIME_BITS'(1);

      state_nxt        = state_cur;
      interval_changed = 1'b0;

      if (command == CMD_RESET) begin
         state_nxt.cur_interval = cfg.eff_base;
         state_nxt.late_cnt     = '0;
         state_nxt.ontime_cnt   = '0;
         interval_changed       = 1'b1;
      end else if (expected_cur != '0) begin
         if (is_late) begin
            state_nxt.ontime_cnt = '0;
            if (late_inc > LATE_CNT_BITS'(cfg.late_limit)) begin
               // grow; overshoot of the maximum falls back to base
               state_nxt.cur_interval = (grown > (INTERVAL_BITS+1)'(cfg.max_interval))
                                        ? cfg.eff_base : grown[INTERVAL_BITS-1:0];
               state_nxt.late_cnt     = '0;
               interval_changed       = 1'b1;
            end else begin
               state_nxt.late_cnt = late_inc;
            end
         end else begin
            state_nxt.late_cnt = '0;
            if (state_cur.cur_interval > cfg.eff_base) begin
               if (ontime_inc >= cfg.ontime_limit) begin
                  // shrink by half a step, floored at base
                  state_nxt.cur_interval =
                     ((INTERVAL_BITS+1)'(state_cur.cur_interval) < shrink_floor)
                     ? cfg.eff_base
                     : state_cur.cur_interval - INTERVAL_BITS'(half);
                  state_nxt.ontime_cnt   = '0;
                  interval_changed       = 1'b1;
               end else begin
                  state_nxt.ontime_cnt = ontime_inc;
               end
            end else begin
               state_nxt.ontime_cnt = '0;
            end
         end
      end

      // reset command leaves the expected time alone
      if (command == CMD_RESET) begin
         expected_nxt = expected_cur;
      end else begin
         expected_nxt = EXP_BITS'(now_ms) + EXP_BITS'(state_nxt.cur_interval);
      end

      throttled = state_nxt.cur_interval > cfg.eff_base;
   end

endmodule

`default_nettype wire

// ===== rtl/core/adaptive_tick_interval_throttle_core.sv =====
// Top level of the adaptive tick interval throttle: handshake stages, state and result register.
`default_nettype none

// Channel  Direction  Handshake           Payload
// req      in         req_valid/req_stall req_command, req_now_ms[TIME_BITS-1:0]
// rsp      out        rsp_valid/rsp_stall rsp_interval_ms, rsp_throttled, rsp_interval_changed
// csr      in         csr_write_enable    csr_index, csr_write_data (write only)
//
// One beat in, one beat out. Sustained rate is one beat per cycle while rsp is not
// stalled. A beat passes the input register, then the state update and result register,
// which drives rsp_valid. The loop that sets the rate is the state update through
// atit_step and the state register.
// Synchronous reset clears the handshake stages and reloads state to its reset
// values. A stalled rsp holds its beat; req stalls only when both stages are full.

module adaptive_tick_interval_throttle_core
   import atit_pkg::*;
#(
   parameter int unsigned TIME_BITS = ATIT_TIME_BITS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // request channel
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     req_command,
   input  wire logic [TIME_BITS-1:0]     req_now_ms,
   // response channel
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [INTERVAL_BITS-1:0]      rsp_interval_ms,
   output logic                          rsp_throttled,
   output logic                          rsp_interval_changed,
   // configuration write port
   input  wire logic                     csr_write_enable,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [INTERVAL_BITS-1:0] csr_write_data
);

   atit_cfg_type    cfg;
   atit_reload_type reload;

   // input register
   logic                 in_valid_ff, in_valid_in;
   logic                 in_command_ff;
   logic [TIME_BITS-1:0] in_now_ff;

   // block state
   atit_state_type       state_ff, state_in, state_step;
   logic [TIME_BITS:0]   expected_ff, expected_in, expected_step;

   // result register
   logic                     out_valid_ff, out_valid_in;
   logic [INTERVAL_BITS-1:0] out_interval_ff;
   logic                     out_throttled_ff, out_changed_ff;
   logic                     step_throttled, step_changed;

   logic out_free, advance, req_take;

   atit_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg),
      .reload           (reload)
   );

   atit_step #(
      .TIME_BITS (TIME_BITS)
   ) u_step (
      .cfg              (cfg),
      .state_cur        (state_ff),
      .expected_cur     (expected_ff),
      .command          (in_command_ff),
      .now_ms           (in_now_ff),
      .state_nxt        (state_step),
      .expected_nxt     (expected_step),
      .throttled        (step_throttled),
      .interval_changed (step_changed)
   );

   // handshake: the result register frees up when empty or being drained this cycle
   always_comb begin
      out_free  = !out_valid_ff || !rsp_stall;
      advance   = in_valid_ff && out_free;
      req_stall = in_valid_ff && !out_free;
      req_take  = req_valid && !req_stall;

      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end

      // state update; a base write reloads the interval and clears the late run
      state_in    = state_ff;
      expected_in = expected_ff;
      if (advance) begin
         state_in    = state_step;
         expected_in = expected_step;
      end
      if (reload.valid) begin
         state_in.cur_interval = reload.value;
         state_in.late_cnt     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff             <= 1'b0;
         out_valid_ff            <= 1'b0;
         state_ff.cur_interval   <= RST_CUR_INTERVAL;
         state_ff.late_cnt       <= '0;
         state_ff.ontime_cnt     <= '0;
         expected_ff             <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
         expected_ff  <= expected_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_command_ff <= req_command;
         in_now_ff     <= req_now_ms;
      end
      if (advance) begin
         out_interval_ff  <= state_step.cur_interval;
         out_throttled_ff <= step_throttled;
         out_changed_ff   <= step_changed;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_interval_ms      = out_interval_ff;
   assign rsp_throttled        = out_throttled_ff;
   assign rsp_interval_changed = out_changed_ff;

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the adaptive tick interval throttle core.
`timescale 1ns / 100ps

module tb
   import atit_pkg::*;
();

   localparam int STAMP_BITS   = ATIT_TIME_BITS_DEFAULT;
   localparam int RESET_CYCLES = 7;
   localparam int IDLE_CYCLES  = 6;    // margin on top of the core latency
   localparam int QUIET_LIMIT  = 500;  // cycles with no beat on either side
   localparam int REG_COUNT    = 7;
   localparam int PHASES       = 12;
   localparam int LONG_PHASE   = 6;    // both run limits at 255
   localparam int PHASE_ITEMS  = 117;
   localparam int LONG_ITEMS   = 620;

   // one result beat
   typedef struct packed {
      logic [INTERVAL_BITS-1:0] interval;
      logic                     throttled;
      logic                     changed;
   } interval_beat_type;

   typedef enum logic {ROW_BEAT, ROW_CSR} row_kind_type;

   // one line of the directed plan: a request beat or a register write
   typedef struct packed {
      row_kind_type             kind;
      logic                     cmd;
      logic [CSR_IDX_BITS-1:0]  idx;
      logic [STAMP_BITS-1:0]    value;   // timestamp, or write data
      logic                     typed;   // expectation written in by hand
      interval_beat_type        want;
   } plan_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_command = CMD_TICK;
   logic [STAMP_BITS-1:0]    req_now_ms = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [INTERVAL_BITS-1:0] rsp_interval_ms;
   logic                     rsp_throttled;
   logic                     rsp_interval_changed;
   logic                     csr_write_enable = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [INTERVAL_BITS-1:0] csr_write_data = '0;

   // shadow registers
   logic [INTERVAL_BITS-1:0] m_base = RST_BASE_INTERVAL;
   logic [INTERVAL_BITS-1:0] m_min = RST_MIN_INTERVAL;
   logic [INTERVAL_BITS-1:0] m_max = RST_MAX_INTERVAL;
   logic [INTERVAL_BITS-1:0] m_step = RST_INTERVAL_STEP;
   logic [INTERVAL_BITS-1:0] m_thresh = RST_LATE_THRESHOLD;
   logic [LIMIT_BITS-1:0]    m_late_lim = RST_LATE_LIMIT;
   logic [LIMIT_BITS-1:0]    m_ontime_lim = RST_ONTIME_LIMIT;

   // shadow state
   logic [INTERVAL_BITS-1:0] m_cur = RST_CUR_INTERVAL;
   logic [LATE_CNT_BITS-1:0] m_late_cnt = '0;
   logic [ONTIME_BITS-1:0]   m_ontime_cnt = '0;
   logic [STAMP_BITS:0]      m_expected = '0;   // zero: not armed yet

   interval_beat_type owed_intervals[$];
   int                mismatches = 0;
   int                gap_pct = 0;     // chance of a sender gap after each beat
   int                stall_pct = 0;   // per-cycle chance of a receiver stall burst

   adaptive_tick_interval_throttle_core #(
      .TIME_BITS(STAMP_BITS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_command),
      .req_now_ms(req_now_ms),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_interval_ms(rsp_interval_ms),
      .rsp_throttled(rsp_throttled),
      .rsp_interval_changed(rsp_interval_changed),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // base as actually used: never under the minimum, never zero
   function automatic logic [INTERVAL_BITS-1:0] floor_base();
      logic [INTERVAL_BITS-1:0] b;
      b = (m_base < m_min) ? m_min : m_base;
      if (b == '0) begin
         b = INTERVAL_BITS'(1);
      end
      return b;
   endfunction

   function automatic void load_reg(input logic [CSR_IDX_BITS-1:0] idx,
                                    input logic [INTERVAL_BITS-1:0] data);
      case (idx)
         REG_BASE_INTERVAL: begin
            // base write reloads the interval and drops the late run
            m_base     = data;
            m_cur      = floor_base();
            m_late_cnt = '0;
         end
         REG_MIN_INTERVAL:   m_min = data;
         REG_MAX_INTERVAL:   m_max = data;
         REG_INTERVAL_STEP:  m_step = data;
         REG_LATE_THRESHOLD: m_thresh = data;
         REG_LATE_LIMIT:     m_late_lim = data[LIMIT_BITS-1:0];
         REG_ONTIME_LIMIT:   m_ontime_lim = data[LIMIT_BITS-1:0];
         default: ;
      endcase
   endfunction

   // advance the shadow state by one request beat, return its result
   function automatic interval_beat_type throttle_step(input logic cmd,
                                                       input logic [STAMP_BITS-1:0] now);
      logic [INTERVAL_BITS-1:0] base;
      logic [INTERVAL_BITS:0]   grown;
      interval_beat_type        r;
      base = floor_base();
      r    = '0;
      if (cmd == CMD_RESET) begin
         // back to base; expected tick time stays as it was
         m_cur        = base;
         m_late_cnt   = '0;
         m_ontime_cnt = '0;
         r.changed    = 1'b1;
      end else begin
         if (m_expected != '0) begin
            if (64'(now) > 64'(m_expected) + 64'(m_thresh)) begin
               m_late_cnt   = m_late_cnt + 1'b1;
               m_ontime_cnt = '0;
               if (m_late_cnt > LATE_CNT_BITS'(m_late_lim)) begin
                  // sum is 17 bits wide, so wrap past 16 bits falls back too
                  grown      = (INTERVAL_BITS+1)'(m_cur) + (INTERVAL_BITS+1)'(m_step);
                  m_cur      = (grown > (INTERVAL_BITS+1)'(m_max)) ? base
                                                                  : grown[INTERVAL_BITS-1:0];
                  m_late_cnt = '0;
                  r.changed  = 1'b1;
               end
            end else begin
               // early counts as on time
               m_late_cnt = '0;
               if (m_cur > base) begin
                  m_ontime_cnt = m_ontime_cnt + 1'b1;
                  if (m_ontime_cnt >= m_ontime_lim) begin
                     if ((INTERVAL_BITS+1)'(m_cur) <
                         (INTERVAL_BITS+1)'(base) + (INTERVAL_BITS+1)'(m_step >> 1)) begin
                        m_cur = base;
                     end else begin
                        m_cur = m_cur - (m_step >> 1);
                     end
                     m_ontime_cnt = '0;
                     r.changed    = 1'b1;
                  end
               end else begin
                  m_ontime_cnt = '0;
               end
            end
         end
         // the first tick only lands here: it arms the next expected time
         m_expected = {1'b0, now} + (STAMP_BITS+1)'(m_cur);
      end
      r.interval  = m_cur;
      r.throttled = (m_cur > base);
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Plan builders
   // ---------------------------------------------------------------------

   function automatic plan_row_type beat_row(input logic c, input logic [STAMP_BITS-1:0] stamp);
      plan_row_type r;
      r       = '0;
      r.kind  = ROW_BEAT;
      r.cmd   = c;
      r.value = stamp;
      return r;
   endfunction

   function automatic plan_row_type known_row(input logic c,
                                              input logic [STAMP_BITS-1:0] stamp,
                                              input logic [INTERVAL_BITS-1:0] intv,
                                              input logic thr, input logic chg);
      plan_row_type r;
      r       = beat_row(c, stamp);
      r.typed = 1'b1;
      r.want  = '{intv, thr, chg};
      return r;
   endfunction

   function automatic plan_row_type reg_row(input logic [CSR_IDX_BITS-1:0] idx,
                                            input logic [INTERVAL_BITS-1:0] data);
      plan_row_type r;
      r       = '0;
      r.kind  = ROW_CSR;
      r.idx   = idx;
      r.value = STAMP_BITS'(data);
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("%0t ns: %s", $time, what);
   endtask

   // present one request beat, hold it through stalls, predict on accept
   task automatic drive_beat(input logic cmd, input logic [STAMP_BITS-1:0] now,
                             input logic typed, input interval_beat_type want);
      interval_beat_type got;
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_now_ms  <= now;
      do @(posedge clock); while (req_stall !== 1'b0);
      got = throttle_step(cmd, now);
      owed_intervals.push_back(typed ? want : got);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   // wait until every owed beat is back and the pipe has drained
   task automatic settle();
      req_valid <= 1'b0;
      while (owed_intervals.size() != 0) @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [INTERVAL_BITS-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      load_reg(idx, data);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // receiver: random stall bursts at a per-phase rate
   initial begin
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result checker: every accepted rsp beat against the oldest owed one
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      interval_beat_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (owed_intervals.size() == 0) begin
            report_mismatch("rsp beat with nothing owed");
         end else begin
            want = owed_intervals.pop_front();
            if (rsp_interval_ms !== want.interval)
               report_mismatch($sformatf("interval_ms got %0d want %0d",
                                         rsp_interval_ms, want.interval));
            if (rsp_throttled !== want.throttled)
               report_mismatch($sformatf("throttled got %b want %b",
                                         rsp_throttled, want.throttled));
            if (rsp_interval_changed !== want.changed)
               report_mismatch($sformatf("interval_changed got %b want %b",
                                         rsp_interval_changed, want.changed));
         end
      end
   end

   // watchdog: too long with no beat on either channel ends the run
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      plan_row_type             plan[$];
      logic [INTERVAL_BITS-1:0] vals[REG_COUNT];
      logic [INTERVAL_BITS-1:0] data;
      logic [CSR_IDX_BITS-1:0]  idx;
      logic [63:0]              t;
      logic                     cmd;
      logic                     noise_on;
      int                       ph, k, items, late_pct, roll, start;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, starting from reset values:
      // base 100, min 10, max 1000, step 50, threshold 50, late limit 3, on-time limit 10.
      gap_pct   = 25;
      stall_pct = 6;
      plan = '{
         known_row(CMD_RESET, 48'd0, 16'd100, 1'b0, 1'b1),   // reset command, unarmed
         known_row(CMD_TICK, 48'd0, 16'd100, 1'b0, 1'b0),    // first tick only arms
         beat_row(CMD_TICK, 48'd151),                        // one past threshold: late
         beat_row(CMD_TICK, 48'd302),
         beat_row(CMD_TICK, 48'd453),
         beat_row(CMD_TICK, 48'd604),                        // fourth late tick grows
         reg_row(REG_ONTIME_LIMIT, 16'd1),
         beat_row(CMD_TICK, 48'd754),                        // right on time: shrink
         beat_row(CMD_TICK, 48'd879),                        // shrink lands on base
         beat_row(CMD_TICK, 48'd979),                        // on time at base
         beat_row(CMD_TICK, 48'd500),                        // early tick
         reg_row(REG_LATE_LIMIT, 16'd0),
         beat_row(CMD_TICK, 48'd200000),                     // single late tick grows
         known_row(CMD_RESET, 48'hFFFF_FFFF_FFFF, 16'd100, 1'b0, 1'b1),
         beat_row(CMD_TICK, 48'hFFFF_FFFF_FFFF),             // top of the time range
         beat_row(CMD_TICK, 48'd0),                          // time goes back: on time
         reg_row(REG_MAX_INTERVAL, 16'hFFFF),
         reg_row(REG_INTERVAL_STEP, 16'hFFFF),
         beat_row(CMD_TICK, 48'd200000),                     // grow carries past 16 bits
         reg_row(REG_MAX_INTERVAL, 16'd50),
         reg_row(REG_INTERVAL_STEP, 16'd10),
         beat_row(CMD_TICK, 48'd400000),                     // base above max
         reg_row(REG_LATE_THRESHOLD, 16'hFFFF),
         beat_row(CMD_TICK, 48'd400100),
         reg_row(REG_LATE_THRESHOLD, 16'd0),
         beat_row(CMD_TICK, 48'd400201),                     // late by 1 with zero threshold
         reg_row(REG_MIN_INTERVAL, 16'd0),
         reg_row(REG_BASE_INTERVAL, 16'd0),                  // base and min zero
         known_row(CMD_RESET, 48'd0, 16'd1, 1'b0, 1'b1),
         reg_row(REG_MIN_INTERVAL, 16'd500),                 // min raised, no reload
         beat_row(CMD_TICK, 48'd400202)
      };
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            settle();
            write_reg(plan[i].idx, plan[i].value[INTERVAL_BITS-1:0]);
         end else begin
            drive_beat(plan[i].cmd, plan[i].value, plan[i].typed, plan[i].want);
         end
      end

      // Random phases: each one reprograms every register, then runs ticks that
      // mostly track the expected time with jitter around the late threshold.
      for (ph = 0; ph < PHASES; ph++) begin
         settle();
         if (ph == LONG_PHASE) begin
            // long late run to reach 256, then a long on-time run to reach 255
            vals[REG_BASE_INTERVAL]  = 16'd50;
            vals[REG_MIN_INTERVAL]   = 16'd10;
            vals[REG_MAX_INTERVAL]   = 16'hFFFF;
            vals[REG_INTERVAL_STEP]  = 16'd100;
            vals[REG_LATE_THRESHOLD] = 16'd20;
            vals[REG_LATE_LIMIT]     = 16'd255;
            vals[REG_ONTIME_LIMIT]   = 16'd255;
         end else begin
            vals[REG_BASE_INTERVAL]  = INTERVAL_BITS'($urandom_range(1, 400));
            vals[REG_MIN_INTERVAL]   = INTERVAL_BITS'($urandom_range(1, 300));
            vals[REG_MAX_INTERVAL]   = INTERVAL_BITS'($urandom_range(1, 1500));
            vals[REG_INTERVAL_STEP]  = INTERVAL_BITS'($urandom_range(0, 300));
            vals[REG_LATE_THRESHOLD] = INTERVAL_BITS'($urandom_range(0, 200));
            vals[REG_LATE_LIMIT]     = INTERVAL_BITS'($urandom_range(0, 5));
            vals[REG_ONTIME_LIMIT]   = INTERVAL_BITS'($urandom_range(1, 8));
            // now and then push a register to one end of its range
            for (k = 0; k < REG_COUNT; k++) begin
               idx = CSR_IDX_BITS'(k);
               if ($urandom_range(0, 7) == 0) begin
                  if ($urandom_range(0, 1) == 1) begin
                     vals[k] = (idx >= REG_LATE_LIMIT) ? 16'd255 : 16'hFFFF;
                  end else begin
                     vals[k] = (idx == REG_INTERVAL_STEP || idx == REG_LATE_THRESHOLD ||
                                idx == REG_LATE_LIMIT) ? 16'd0 : 16'd1;
                  end
               end
            end
         end
         // write order rotated from a random start; byte-wide registers get junk in the upper byte
         start = $urandom_range(0, REG_COUNT - 1);
         for (k = 0; k < REG_COUNT; k++) begin
            idx  = CSR_IDX_BITS'((start + k) % REG_COUNT);
            data = vals[idx];
            if (idx >= REG_LATE_LIMIT) begin
               data[INTERVAL_BITS-1:LIMIT_BITS] = (INTERVAL_BITS-LIMIT_BITS)'($urandom);
            end
            write_reg(idx, data);
         end

         // no idling at all in the final phase
         if (ph == PHASES - 1) begin
            gap_pct   = 0;
            stall_pct = 0;
         end else begin
            gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 15);
         end
         noise_on = (ph != LONG_PHASE);
         items    = (ph == LONG_PHASE) ? LONG_ITEMS : PHASE_ITEMS;
         late_pct = $urandom_range(10, 60);

         for (k = 0; k < items; k++) begin
            if (ph == LONG_PHASE) begin
               late_pct = (k < items / 2) ? 100 : 0;
            end
            roll = $urandom_range(0, 99);
            cmd  = CMD_TICK;
            t    = {$urandom, $urandom};
            if ($urandom_range(0, 3) == 0) begin
               t = 64'hFFFF_FFFF_FFFF - 64'($urandom_range(0, 3000));   // near wrap
            end
            if (noise_on && roll < 3) begin
               cmd = CMD_RESET;
            end else if ((noise_on && roll < 7) || m_expected == '0) begin
               // stray timestamp, keeps the random value
            end else if ($urandom_range(0, 99) < late_pct) begin
               t = 64'(m_expected) + 64'(m_thresh) + 64'd1 +
                   (roll[0] ? 64'd0 : 64'($urandom_range(0, 40)));
            end else begin
               case ($urandom_range(0, 3))
                  0:       t = 64'(m_expected) + 64'(m_thresh);   // last on-time ms
                  1:       t = 64'(m_expected) + 64'($urandom_range(0, m_thresh));
                  2:       t = 64'(m_expected) - 64'($urandom_range(1, 500));
                  default: t = 64'(m_expected);
               endcase
            end
            drive_beat(cmd, t[STAMP_BITS-1:0], 1'b0, '0);
         end
      end

      settle();
      repeat (IDLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
